/* hdl/grp_pkg.sv */
// Shared types and constants for the gray replicate-pad block.
`default_nettype none
package grp_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned CRD_W   = 13;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned FRAC_W  = 10;

  localparam logic [9:0] W_C0 = 10'd307;
  localparam logic [9:0] W_C1 = 10'd604;
  localparam logic [9:0] W_C2 = 10'd113;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CRD_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CRD_W-1:0] HEIGHT_RST = 13'd480;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    SEL_LO,
    SEL_MID,
    SEL_HI
  } sel_e;

  // One classified pixel: everything the emitter needs to produce its copies.
  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [CRD_W-1:0] col1;
    logic [CRD_W-1:0] row1;
    logic [CRD_W-1:0] wid1;
    logic [CRD_W-1:0] hgt1;
    logic             top;
    logic             bot;
    logic             left;
    logic             right;
    logic             last_pix;
  } desc_t;

  function automatic logic [CRD_W-1:0] eff_dim(input logic [CRD_W-1:0] v);
    logic [CRD_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CRD_W'(1);
    end else if ({1'b0, v} > (CRD_W + 1)'(MAX_DIM)) begin
      r = CRD_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/grp_front.sv */
// Front end: configuration registers, raster position, gray conversion, edge classification.
`default_nettype none
module grp_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [grp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [grp_pkg::CRD_W-1:0]         cfg_data_i,
  input  wire logic                              pix_valid_i,
  input  wire logic [grp_pkg::IN_TDATA_W-1:0]    pix_data_i,
  output logic                                   pix_ready_o,
  output logic                                   desc_valid_o,
  output grp_pkg::desc_t                         desc_o,
  input  wire logic                              desc_ready_i
);
  import grp_pkg::*;

  logic [CRD_W-1:0] width_q, height_q;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [CRD_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0] w_m1, h_m1;
  logic [SUM_W-1:0] sum;
  logic             at_right, at_bot, accept;

  assign w_eff = eff_dim(width_q);
  assign h_eff = eff_dim(height_q);
  assign w_m1  = CNT_W'(w_eff - CRD_W'(1));
  assign h_m1  = CNT_W'(h_eff - CRD_W'(1));

  assign at_right = (col_q == w_m1);
  assign at_bot   = (row_q == h_m1);

  assign sum = SUM_W'(pix_data_i[7:0])   * SUM_W'(W_C0)
             + SUM_W'(pix_data_i[15:8])  * SUM_W'(W_C1)
             + SUM_W'(pix_data_i[23:16]) * SUM_W'(W_C2);

  assign pix_ready_o  = desc_ready_i;
  assign desc_valid_o = pix_valid_i;
  assign accept       = pix_valid_i && desc_ready_i;

  always_comb begin
    desc_o.gray     = sum[FRAC_W +: PIX_W];
    desc_o.col1     = CRD_W'(col_q) + CRD_W'(1);
    desc_o.row1     = CRD_W'(row_q) + CRD_W'(1);
    desc_o.wid1     = w_eff + CRD_W'(1);
    desc_o.hgt1     = h_eff + CRD_W'(1);
    desc_o.top      = (row_q == '0);
    desc_o.bot      = at_bot;
    desc_o.left     = (col_q == '0);
    desc_o.right    = at_right;
    desc_o.last_pix = at_bot && at_right;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_valid_i &&
        (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT)) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (at_right) begin
        col_d = '0;
        row_d = at_bot ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_valid_i && cfg_index_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/grp_fifo.sv */
// Small first-word-fall-through queue of pixel descriptors.
`default_nettype none
module grp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  input  wire grp_pkg::desc_t wr_data_i,
  output logic                wr_ready_o,
  output logic                rd_valid_o,
  output grp_pkg::desc_t      rd_data_o,
  input  wire logic           rd_pop_i
);
  import grp_pkg::*;

  desc_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               push, pop;

  assign wr_ready_o = (cnt_q != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (FIFO_AW + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (FIFO_AW + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/grp_back.sv */
// Back end: walks the border copies of each descriptor into a registered output stage.
`default_nettype none
module grp_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            desc_valid_i,
  input  wire grp_pkg::desc_t                  desc_i,
  output logic                                 desc_pop_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [grp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tuser
);
  import grp_pkg::*;

  sel_e             row_q, col_q, row_eff, col_eff, col_start;
  logic             first_q, out_valid_q;
  logic [PIX_W-1:0] gray_q;
  logic [CRD_W-1:0] pcol_q, prow_q, pcol, prow;
  logic             last_q, fend_q;
  logic             emit, row_fin, col_fin, last;

  assign col_start = desc_i.left ? SEL_LO : SEL_MID;
  assign row_eff   = first_q ? (desc_i.top ? SEL_LO : SEL_MID) : row_q;
  assign col_eff   = first_q ? col_start : col_q;
  assign row_fin   = (row_eff == SEL_HI) || (row_eff == SEL_MID && !desc_i.bot);
  assign col_fin   = (col_eff == SEL_HI) || (col_eff == SEL_MID && !desc_i.right);
  assign last      = row_fin && col_fin;

  assign emit       = desc_valid_i && (!out_valid_q || m_axis_tready);
  assign desc_pop_o = emit && last;

  always_comb begin
    case (col_eff)
      SEL_LO:  pcol = '0;
      SEL_MID: pcol = desc_i.col1;
      SEL_HI:  pcol = desc_i.wid1;
      default: pcol = '0;
    endcase
    case (row_eff)
      SEL_LO:  prow = '0;
      SEL_MID: prow = desc_i.row1;
      SEL_HI:  prow = desc_i.hgt1;
      default: prow = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      row_q       <= SEL_MID;
      col_q       <= SEL_MID;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        if (last) begin
          first_q <= 1'b1;
        end else begin
          first_q <= 1'b0;
          if (col_fin) begin
            col_q <= col_start;
            row_q <= (row_eff == SEL_LO) ? SEL_MID : SEL_HI;
          end else begin
            row_q <= row_eff;
            col_q <= (col_eff == SEL_LO) ? SEL_MID : SEL_HI;
          end
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      gray_q <= desc_i.gray;
      pcol_q <= pcol;
      prow_q <= prow;
      last_q <= last;
      fend_q <= last && desc_i.last_pix;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - PIX_W - 2 * CRD_W)'(0), prow_q, pcol_q, gray_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = fend_q;

endmodule
`default_nettype wire

/* hdl/gray_replicate_pad_core.sv */
// Top level of the gray conversion and replicate border padding block.
// Input stream s_axis: one 24-bit pixel per transaction in raster order.
// Output stream m_axis: one padded-frame pixel per transaction with its coordinates;
// tlast marks the final copy of an input pixel, tuser the frame's final copy.
// Config channel: cfg_index_i 0 = image_width, 1 = image_height; a write restarts
// the frame at the top-left pixel. Other indexes are ignored. cfg_ready_o is always 1.
// The first copy of a pixel is written into the queue and then into the output
// register, from which it is presented on m_axis. While m_axis does not stall,
// interior pixels flow at one per cycle and a pixel on an edge is emitted at one
// copy per cycle (2 to 9 copies), set by the single output register that the
// emitter fills one copy at a time. A four-entry queue between the classifier
// and the emitter absorbs the difference.
// Reset: dimensions return to 640 x 480, position to the top-left pixel,
// the queue and output stage empty.
// When m_axis stalls, the output register holds its transaction, the emitter
// waits, the queue fills and s_axis_tready drops once it is full.
`default_nettype none
module gray_replicate_pad_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [grp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [grp_pkg::CRD_W-1:0]           cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // chan0 [7:0], chan1 [15:8], chan2 [23:16]
  input  wire logic [grp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // gray [7:0], pad_col [20:8], pad_row [33:21], zero [39:34]
  output logic [grp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // last_copy
  output logic                                     m_axis_tlast,
  // frame_end
  output logic                                     m_axis_tuser
);
  import grp_pkg::*;

  logic  fr_valid, fr_ready, q_valid, q_pop;
  desc_t fr_desc, q_desc;

  assign cfg_ready_o = 1'b1;

  grp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pix_valid_i  (s_axis_tvalid),
    .pix_data_i   (s_axis_tdata),
    .pix_ready_o  (s_axis_tready),
    .desc_valid_o (fr_valid),
    .desc_o       (fr_desc),
    .desc_ready_i (fr_ready)
  );

  grp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_data_i  (fr_desc),
    .wr_ready_o (fr_ready),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_desc),
    .rd_pop_i   (q_pop)
  );

  grp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_valid_i  (q_valid),
    .desc_i        (q_desc),
    .desc_pop_o    (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for gray_replicate_pad_core: random pixel streams checked against a padded-copy predictor.

typedef struct packed {
  logic [grp_pkg::PIX_W-1:0] gray;
  logic [grp_pkg::CRD_W-1:0] col;
  logic [grp_pkg::CRD_W-1:0] row;
  logic                      last_copy;
  logic                      frame_end;
} pad_copy_t;

class pad_copy_scoreboard;
  logic [grp_pkg::CRD_W-1:0] width_reg;
  logic [grp_pkg::CRD_W-1:0] height_reg;
  int unsigned               col_pos;
  int unsigned               row_pos;
  pad_copy_t                 copy_q[$];
  int unsigned               errors;

  function new();
    width_reg  = grp_pkg::WIDTH_RST;
    height_reg = grp_pkg::HEIGHT_RST;
    col_pos    = 0;
    row_pos    = 0;
    errors     = 0;
  endfunction

  function int unsigned clamp_dim(logic [grp_pkg::CRD_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > int'(grp_pkg::MAX_DIM)) return grp_pkg::MAX_DIM;
    return int'(v);
  endfunction

  function void write_reg(logic [grp_pkg::CFG_IDX_W-1:0] idx, logic [grp_pkg::CRD_W-1:0] val);
    if (idx == grp_pkg::CFG_IMAGE_WIDTH) begin
      width_reg = val;
      col_pos   = 0;
      row_pos   = 0;
    end else if (idx == grp_pkg::CFG_IMAGE_HEIGHT) begin
      height_reg = val;
      col_pos    = 0;
      row_pos    = 0;
    end
  endfunction

  // Expected copies of one pixel in padded row-major order.
  function void add_pixel(logic [grp_pkg::IN_TDATA_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned sum;
    int unsigned rows[3];
    int unsigned cols[3];
    int          nr;
    int          nc;
    bit          last_px;
    pad_copy_t   cp;
    w   = clamp_dim(width_reg);
    h   = clamp_dim(height_reg);
    sum = int'(px[7:0]) * int'(grp_pkg::W_C0) + int'(px[15:8]) * int'(grp_pkg::W_C1)
        + int'(px[23:16]) * int'(grp_pkg::W_C2);
    last_px = (row_pos == h - 1) && (col_pos == w - 1);
    nr = 0;
    nc = 0;
    if (row_pos == 0) begin
      rows[nr] = 0;
      nr++;
    end
    rows[nr] = row_pos + 1;
    nr++;
    if (row_pos == h - 1) begin
      rows[nr] = h + 1;
      nr++;
    end
    if (col_pos == 0) begin
      cols[nc] = 0;
      nc++;
    end
    cols[nc] = col_pos + 1;
    nc++;
    if (col_pos == w - 1) begin
      cols[nc] = w + 1;
      nc++;
    end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        cp.gray      = sum[17:10];
        cp.col       = cols[j][grp_pkg::CRD_W-1:0];
        cp.row       = rows[i][grp_pkg::CRD_W-1:0];
        cp.last_copy = (i == nr - 1) && (j == nc - 1);
        cp.frame_end = cp.last_copy && last_px;
        copy_q.push_back(cp);
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 50) $display("ERROR: %s", msg);
  endtask

  task check_copy(logic [grp_pkg::OUT_TDATA_W-1:0] td, logic tl, logic tu);
    pad_copy_t e;
    if (copy_q.size() == 0) begin
      report($sformatf("unexpected copy tdata=%h tlast=%b tuser=%b", td, tl, tu));
      return;
    end
    e = copy_q.pop_front();
    if (td[7:0] != e.gray)
      report($sformatf("gray at r%0d c%0d: got %0d exp %0d", e.row, e.col, td[7:0], e.gray));
    if (td[20:8] != e.col)
      report($sformatf("pad_col at r%0d: got %0d exp %0d", e.row, td[20:8], e.col));
    if (td[33:21] != e.row)
      report($sformatf("pad_row at c%0d: got %0d exp %0d", e.col, td[33:21], e.row));
    if (td[39:34] != '0)
      report($sformatf("pad bits at r%0d c%0d: got %h", e.row, e.col, td[39:34]));
    if (tl != e.last_copy)
      report($sformatf("last_copy at r%0d c%0d: got %b exp %b", e.row, e.col, tl, e.last_copy));
    if (tu != e.frame_end)
      report($sformatf("frame_end at r%0d c%0d: got %b exp %b", e.row, e.col, tu, e.frame_end));
  endtask
endclass

module tb;
  import grp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 380;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid;
  wire logic              cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CRD_W-1:0]       cfg_data;
  logic                   s_tvalid;
  wire logic              s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  wire logic              m_tvalid;
  logic                   m_tready;
  wire logic [OUT_TDATA_W-1:0] m_tdata;
  wire logic              m_tlast;
  wire logic              m_tuser;

  pad_copy_scoreboard sb;
  int                 tx_rate;
  int                 rx_rate;
  int                 items_sent;
  int                 idle_cycles;

  gray_replicate_pad_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_rate > 0 && $urandom_range(0, 99) < rx_rate) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_copy(m_tdata, m_tlast, m_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** gray_replicate_pad_core: FAILED **");
      $finish;
    end
  end

  // Leaves cfg_valid high; the next pixel transaction lowers it.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CRD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_dims(logic [CRD_W-1:0] w, logic [CRD_W-1:0] h);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_pixel(logic [IN_TDATA_W-1:0] px);
    cfg_valid <= 1'b0;
    if (tx_rate > 0 && $urandom_range(0, 99) < tx_rate) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk_i); while (!s_tready);
    sb.add_pixel(px);
    items_sent++;
  endtask

  task automatic send_random(int n);
    logic [IN_TDATA_W-1:0] px;
    for (int k = 0; k < n; k++) begin
      px = IN_TDATA_W'($urandom());
      for (int ch = 0; ch < 3; ch++) begin
        case ($urandom_range(0, 5))
          0:       px[ch*8 +: 8] = 8'h00;
          1:       px[ch*8 +: 8] = 8'hFF;
          default: ;
        endcase
      end
      send_pixel(px);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.copy_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CRD_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CRD_W'($urandom_range(4096, 8191));
      2, 3:    return CRD_W'($urandom_range(7, 24));
      default: return CRD_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    logic [CRD_W-1:0] w_val;
    logic [CRD_W-1:0] h_val;
    int               sel;
    int               area;
    int               n;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    tx_rate     = 20;
    rx_rate     = 20;
    items_sent  = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset dimensions, top-left corner first
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h0000FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF0000);
    send_pixel(24'h808080);
    // 1 x 1 image: nine copies per pixel
    drain();
    set_dims(13'd1, 13'd1);
    send_random(2);
    // zero dimensions act as one
    drain();
    set_dims(13'd0, 13'd0);
    send_pixel(24'hFFFFFF);
    // frame wrap
    drain();
    set_dims(13'd3, 13'd2);
    send_random(7);
    // unused indexes must not restart the frame
    drain();
    set_dims(13'd2, 13'd2);
    send_random(1);
    drain();
    cfg_write(CFG_UNUSED_LO, 13'h1FFF);
    send_random(2);
    drain();
    cfg_write(CFG_UNUSED_HI, 13'h0000);
    send_random(1);
    // oversized dimensions clamp
    drain();
    set_dims(13'h1FFF, 13'd4096);
    send_random(2);
    drain();
    set_dims(13'd4096, 13'h1FFF);
    send_random(2);

    while (items_sent < ITEM_TARGET) begin
      drain();
      if (items_sent >= ITEM_TARGET - 60) begin
        tx_rate = 0;
        rx_rate = 0;
      end else begin
        tx_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        rx_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      w_val = pick_dim();
      h_val = pick_dim();
      sel   = $urandom_range(0, 3);
      if (sel != 1) cfg_write(CFG_IMAGE_WIDTH, w_val);
      if (sel != 2) cfg_write(CFG_IMAGE_HEIGHT, h_val);
      if (sel == 3)
        cfg_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), CRD_W'($urandom()));
      area = sb.clamp_dim(sb.width_reg) * sb.clamp_dim(sb.height_reg);
      if (area <= 48) n = area * $urandom_range(1, 3) + $urandom_range(0, 3);
      else n = $urandom_range(8, 48);
      if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
      send_random(n);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** gray_replicate_pad_core: PASSED **");
    end else begin
      $display("** gray_replicate_pad_core: FAILED **");
    end
    $finish;
  end
endmodule
